// ----- hdl/hep_pkg.sv -----
// ----------------------------------------------------------------------------
// hep_pkg
// Shared types, constants and curve tables for the Hilbert prefix-reuse encoder.
// ----------------------------------------------------------------------------
package hep_pkg;

	localparam int MAX_ORDER_DEF = 32;
	localparam int COORD_W       = 32;
	localparam int CODE_W        = 64;
	localparam int ORDER_W       = 6;
	localparam int POS_W         = 5;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN,
		ST_FIN
	} state_t;

	// leading-one search result
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} lead_t;

	localparam logic [1:0] DIGIT_TABLE [16] = '{
		2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2,
		2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0
	};

	localparam logic [1:0] ORIENT_TABLE [16] = '{
		2'd1, 2'd0, 2'd3, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1,
		2'd2, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0, 2'd2
	};

endpackage

// ----- hdl/hep_lead_enc.sv -----
// ----------------------------------------------------------------------------
// hep_lead_enc
// Two-stage leading-one search over a 32-bit word: per-byte search registered
// on load, byte selection combinational from the registered stage.
// ----------------------------------------------------------------------------
module hep_lead_enc (
	input  logic                        clk,
	input  logic                        load,
	input  logic [hep_pkg::COORD_W-1:0] vec,
	output hep_pkg::lead_t              lead
);
	import hep_pkg::*;

	localparam int NBYTES = COORD_W / 8;

	logic [NBYTES-1:0] byte_any_s1;
	logic [2:0]        byte_pos_s1 [NBYTES];
	logic [2:0]        byte_pos_d  [NBYTES];

	always_comb begin
		for (int k = 0; k < NBYTES; k++) begin
			byte_pos_d[k] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (vec[8*k + b]) begin
					byte_pos_d[k] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NBYTES; k++) begin
				byte_any_s1[k] <= |vec[8*k +: 8];
				byte_pos_s1[k] <= byte_pos_d[k];
			end
		end
	end

	always_comb begin
		lead = '0;
		for (int k = 0; k < NBYTES; k++) begin
			if (byte_any_s1[k]) begin
				lead.found = 1'b1;
				lead.pos   = {2'(k), byte_pos_s1[k]};
			end
		end
	end

endmodule

// ----- hdl/hilbert_encode_prefix_reuse.sv -----
// ----------------------------------------------------------------------------
// hilbert_encode_prefix_reuse
// 2D Hilbert encoder with four-state orientation tables that recomputes only
// the levels at and below the highest bit changed since the previous point.
// ----------------------------------------------------------------------------
// An item passes from acceptance through a prepare state, a run state that
// recomputes the levels from start down to level 0 (skipped when the previous
// lookahead said the point repeats) and a finish state that waits for the
// output register. The orientation walk advances one two-bit level per cycle
// through the state tables. The result sits in an output register, so the
// next item is taken while a result still waits. start is the highest bit at
// which the previous item's point and its lookahead differed, limited to
// order - 1.
// ----------------------------------------------------------------------------
module hilbert_encode_prefix_reuse #(
	parameter int MAX_ORDER = hep_pkg::MAX_ORDER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [5:0]   cfg_data,       // order
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // x, y, next_x, next_y
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata    // code
);
	import hep_pkg::*;

	localparam int LW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam logic [LW-1:0] TOP_RESET = LW'(MAX_ORDER - 1);

	state_t state_q, state_d;

	logic [ORDER_W-1:0]  order_q;
	logic [CODE_W-1:0]   prev_code_q;
	logic [LW-1:0]       start_q;
	logic                start_none_q;
	logic [1:0]          orient_q [MAX_ORDER];

	logic [COORD_W-1:0]  x_q, y_q, diff_q;
	logic [LW-1:0]       ordm1_q, lvl_q, start_sat_q;
	logic                run_q, above_zero_q;
	logic [1:0]          s_q;
	logic [CODE_W-1:0]   low_q;
	logic [CODE_W-1:0]   out_q;
	logic                out_valid_q;

	logic [ORDER_W-1:0]  ord_eff;
	logic [LW-1:0]       ordm1, start_sat;
	logic [COORD_W-1:0]  cmask, x_in, y_in, nx_in, ny_in, above_mask;
	logic                accept, fin_go, prep, level_cond;
	logic [3:0]          idx;
	logic [CODE_W-1:0]   code_fin;
	lead_t               lead;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fin_go        = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
	assign prep          = (state_q == ST_PREP);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// effective order and coordinate mask
	always_comb begin
		ord_eff = order_q;
		if (order_q == '0) begin
			ord_eff = ORDER_W'(1);
		end else if (order_q > ORDER_W'(MAX_ORDER)) begin
			ord_eff = ORDER_W'(MAX_ORDER);
		end
		ordm1 = LW'(ord_eff - ORDER_W'(1));
		for (int b = 0; b < COORD_W; b++) begin
			cmask[b] = (ORDER_W'(b) < ord_eff);
		end
		start_sat = (start_q > ordm1) ? ordm1 : start_q;
	end

	assign x_in  = s_axis_tdata[31:0]   & cmask;
	assign y_in  = s_axis_tdata[63:32]  & cmask;
	assign nx_in = s_axis_tdata[95:64]  & cmask;
	assign ny_in = s_axis_tdata[127:96] & cmask;

	always_comb begin
		for (int b = 0; b < COORD_W; b++) begin
			above_mask[b] = (b > int'(lvl_q));
		end
	end

	assign idx        = {s_q, x_q[lvl_q], y_q[lvl_q]};
	assign level_cond = above_zero_q && !diff_q[lvl_q] && (lvl_q != '0);

	hep_lead_enc u_lead (
		.clk  (clk),
		.load (prep),
		.vec  (diff_q),
		.lead (lead)
	);

	// prefix from the previous code above the recomputed levels merged with the new low digits, masked to order
	always_comb begin
		for (int j = 0; j < CODE_W; j++) begin
			code_fin[j] = ((prev_code_q[j] && (!run_q || ((j >> 1) > int'(start_sat_q))))
				|| low_q[j]) && ((j >> 1) <= int'(ordm1_q));
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = run_q ? ST_RUN : ST_FIN;
			end
			ST_RUN: begin
				if (lvl_q == '0) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q      <= ORDER_RESET;
			prev_code_q  <= '0;
			start_q      <= TOP_RESET;
			start_none_q <= 1'b0;
			out_valid_q  <= 1'b0;
			run_q        <= 1'b0;
			for (int i = 0; i < MAX_ORDER; i++) begin
				orient_q[i] <= 2'd0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				order_q <= cfg_data;
			end
			if (accept) begin
				run_q <= !start_none_q;
			end
			if (state_q == ST_RUN && level_cond) begin
				orient_q[lvl_q - LW'(1)] <= ORIENT_TABLE[idx];
			end
			if (fin_go) begin
				prev_code_q  <= code_fin;
				start_none_q <= !lead.found;
				start_q      <= lead.pos[LW-1:0];
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// working registers of the level walk
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q         <= x_in;
			y_q         <= y_in;
			diff_q      <= (x_in ^ nx_in) | (y_in ^ ny_in);
			ordm1_q     <= ordm1;
			start_sat_q <= start_sat;
			lvl_q       <= start_sat;
			s_q         <= (start_sat == ordm1) ? 2'd0 : orient_q[start_sat];
			low_q       <= '0;
		end
		if (prep) begin
			above_zero_q <= ~|(diff_q & above_mask);
		end
		if (state_q == ST_RUN) begin
			low_q        <= {low_q[CODE_W-3:0], DIGIT_TABLE[idx]};
			s_q          <= ORIENT_TABLE[idx];
			above_zero_q <= above_zero_q && !diff_q[lvl_q];
			lvl_q        <= lvl_q - LW'(1);
		end
		if (fin_go) begin
			out_q <= code_fin;
		end
	end

	a_run_has_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> run_q)
		else $error("level walk entered with no levels to compute");

	a_level_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (lvl_q <= ordm1_q))
		else $error("level walk above the curve order");

	a_out_is_prev: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (m_axis_tvalid && (m_axis_tdata == prev_code_q)))
		else $error("delivered code differs from stored previous code");

	a_low_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (low_q == '0))
		else $error("digit accumulator not cleared for a new transaction");

endmodule
